FILE: src/mtc_pkg.sv
`timescale 1ns / 1ps

package mtc_pkg;

  // Field widths fixed by the stream and register formats.
  localparam int ADDR_W     = 48;
  localparam int EADDR_W    = ADDR_W + 1;   // address sums carry one extra bit
  localparam int BYTES_W    = 9;
  localparam int KIND_W     = 3;
  localparam int CIDX_W     = 5;
  localparam int CLS_W      = 4;
  localparam int NEW_W      = 7;
  localparam int COV_W      = 15;
  localparam int CVAL_W     = 48;
  localparam int WLINES_W   = 15;
  localparam int SHIFT_W    = 4;
  localparam int STEP_W     = 13;           // up to one 4 KiB line
  localparam int S_TDATA_W  = 72;
  localparam int M_TDATA_W  = 72;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 48;

  localparam int SH_MIN        = 2;
  localparam int SH_MAX        = 12;
  localparam int MAX_REQ_BYTES = 256;

  localparam int DEF_MAX_LINES    = 16384;
  localparam int DEF_COUNTER_BITS = 48;

  localparam logic [WLINES_W-1:0] WINDOW_LINES_RST = WLINES_W'(1);
  localparam logic [SHIFT_W-1:0]  LINE_SHIFT_RST   = SHIFT_W'(6);

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_BASE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LINES = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LINE_SHIFT   = 2'd2;

  // Command kinds
  localparam logic [KIND_W-1:0] KIND_OTHER       = 3'd0;
  localparam logic [KIND_W-1:0] KIND_CLEAN_EVICT = 3'd1;
  localparam logic [KIND_W-1:0] KIND_WB_DIRTY    = 3'd2;
  localparam logic [KIND_W-1:0] KIND_WB_CLEAN    = 3'd3;
  localparam logic [KIND_W-1:0] KIND_WRITE_CLEAN = 3'd4;

  // Packet classes
  localparam logic [CLS_W-1:0] CLS_NONE        = 4'd0;
  localparam logic [CLS_W-1:0] CLS_META_RD     = 4'd0;
  localparam logic [CLS_W-1:0] CLS_META_WR     = 4'd1;
  localparam logic [CLS_W-1:0] CLS_META_OTHER  = 4'd2;
  localparam logic [CLS_W-1:0] CLS_CLEAN_EVICT = 4'd3;
  localparam logic [CLS_W-1:0] CLS_READ        = 4'd4;
  localparam logic [CLS_W-1:0] CLS_WB_DIRTY    = 4'd5;
  localparam logic [CLS_W-1:0] CLS_WB_CLEAN    = 4'd6;
  localparam logic [CLS_W-1:0] CLS_WRITE_CLEAN = 4'd7;
  localparam logic [CLS_W-1:0] CLS_OTHER_WRITE = 4'd8;
  localparam logic [CLS_W-1:0] CLS_OTHER       = 4'd9;

  // Counter numbering
  typedef logic [CIDX_W-1:0] cnt_idx_t;

  localparam int NUM_COUNTERS = 19;

  localparam cnt_idx_t CNT_PACKETS      = 5'd0;
  localparam cnt_idx_t CNT_META_RD      = 5'd1;
  localparam cnt_idx_t CNT_META_WR      = 5'd2;
  localparam cnt_idx_t CNT_META_OTHER   = 5'd3;
  localparam cnt_idx_t CNT_IN_PF        = 5'd4;
  localparam cnt_idx_t CNT_IN_DEMAND    = 5'd5;
  localparam cnt_idx_t CNT_OUT_PF       = 5'd6;
  localparam cnt_idx_t CNT_OUT_DEMAND   = 5'd7;
  localparam cnt_idx_t CNT_IN_CE        = 5'd8;
  localparam cnt_idx_t CNT_OUT_CE       = 5'd9;
  localparam cnt_idx_t CNT_IN_RD        = 5'd10;
  localparam cnt_idx_t CNT_OUT_RD       = 5'd11;
  localparam cnt_idx_t CNT_IN_WBD       = 5'd12;
  localparam cnt_idx_t CNT_IN_WBC       = 5'd13;
  localparam cnt_idx_t CNT_IN_WRC       = 5'd14;
  localparam cnt_idx_t CNT_IN_OTHER_WR  = 5'd15;
  localparam cnt_idx_t CNT_OUT_WR       = 5'd16;
  localparam cnt_idx_t CNT_IN_OTHER     = 5'd17;
  localparam cnt_idx_t CNT_OUT_OTHER    = 5'd18;
  localparam cnt_idx_t CNT_DISTINCT     = 5'd19;

  typedef struct packed {
    logic                action;
    logic [ADDR_W-1:0]   req_address;
    logic [BYTES_W-1:0]  req_bytes;
    logic                is_metadata;
    logic                is_read;
    logic                is_write;
    logic                has_data;
    logic                is_prefetch;
    logic [KIND_W-1:0]   command_kind;
    logic [CIDX_W-1:0]   counter_index;
  } item_t;

  // Decoded request, handed from the decode pipe to the sequencer
  typedef struct packed {
    logic [CLS_W-1:0]    cls;
    logic                in_window;
    logic                mark;       // covered-line walk needed
    logic [1:0]          n_bump;     // counters to bump, 0 to 3
    cnt_idx_t [2:0]      bump;
    logic [EADDR_W-1:0]  hi;         // walk stops below this address
    logic [EADDR_W-1:0]  a_start;    // first line-aligned address to mark
    logic [STEP_W-1:0]   step;       // line size in bytes
  } dec_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DEC,
    ST_CNT,
    ST_LINES,
    ST_DONE
  } state_t;

endpackage

FILE: src/mtc_decode.sv
`timescale 1ns / 1ps

module mtc_decode #(
  parameter int MAX_LINES = mtc_pkg::DEF_MAX_LINES,
  parameter int AW        = $clog2(MAX_LINES)
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  mtc_pkg::item_t                      item,
  input  logic [mtc_pkg::ADDR_W-1:0]          window_base,
  input  logic [mtc_pkg::WLINES_W-1:0]        window_lines,
  input  logic [mtc_pkg::SHIFT_W-1:0]         line_shift,
  output logic                                done,
  output mtc_pkg::dec_t                       dec,
  output logic [AW-1:0]                       li_start
);

  localparam int LNW = ($clog2(MAX_LINES + 1) > mtc_pkg::WLINES_W) ?
                       $clog2(MAX_LINES + 1) : mtc_pkg::WLINES_W;
  localparam int EW  = mtc_pkg::EADDR_W;

  logic v1, v2, v3, v4;

  // stage 1: window end and request end
  logic [mtc_pkg::SHIFT_W-1:0] sh_c, s1_sh;
  logic [LNW-1:0]              lines_c;
  logic [mtc_pkg::BYTES_W-1:0] bytes_c;
  logic [EW-1:0]               s1_wend, s1_rend;
  logic                        s1_lnz, s1_bnz;

  always_comb begin
    if (line_shift < mtc_pkg::SHIFT_W'(mtc_pkg::SH_MIN)) begin
      sh_c = mtc_pkg::SHIFT_W'(mtc_pkg::SH_MIN);
    end else if (line_shift > mtc_pkg::SHIFT_W'(mtc_pkg::SH_MAX)) begin
      sh_c = mtc_pkg::SHIFT_W'(mtc_pkg::SH_MAX);
    end else begin
      sh_c = line_shift;
    end
    lines_c = (LNW'(window_lines) > LNW'(MAX_LINES)) ? LNW'(MAX_LINES) : LNW'(window_lines);
    bytes_c = (item.req_bytes > mtc_pkg::BYTES_W'(mtc_pkg::MAX_REQ_BYTES)) ?
              mtc_pkg::BYTES_W'(mtc_pkg::MAX_REQ_BYTES) : item.req_bytes;
  end

  always_ff @(posedge clk) begin
    if (start) begin
      s1_sh   <= sh_c;
      s1_lnz  <= (lines_c != '0);
      s1_bnz  <= (bytes_c != '0);
      s1_wend <= {1'b0, window_base} + (EW'(lines_c) << sh_c);
      s1_rend <= {1'b0, item.req_address} + EW'(bytes_c);
    end
  end

  // stage 2: overlap, class, counters to bump, walk bounds
  logic                          hit;
  logic [mtc_pkg::ADDR_W-1:0]    lo_c, s2_lo;
  mtc_pkg::cnt_idx_t             b1, b2;
  logic [mtc_pkg::CLS_W-1:0]     cls_c;
  logic                          mark_c, inw_c;
  logic [1:0]                    n_c;

  always_comb begin
    hit  = s1_lnz && s1_bnz && ({1'b0, item.req_address} < s1_wend) &&
           ({1'b0, window_base} < s1_rend);
    lo_c = (item.req_address > window_base) ? item.req_address : window_base;
    b1     = mtc_pkg::CNT_PACKETS;
    b2     = mtc_pkg::CNT_PACKETS;
    cls_c  = mtc_pkg::CLS_NONE;
    mark_c = 1'b0;
    inw_c  = 1'b0;
    n_c    = 2'd0;
    if (item.action) begin
      n_c = 2'd0;
    end else if (item.is_metadata) begin
      n_c = 2'd2;
      if (item.is_read) begin
        b1 = mtc_pkg::CNT_META_RD;    cls_c = mtc_pkg::CLS_META_RD;
      end else if (item.is_write) begin
        b1 = mtc_pkg::CNT_META_WR;    cls_c = mtc_pkg::CLS_META_WR;
      end else begin
        b1 = mtc_pkg::CNT_META_OTHER; cls_c = mtc_pkg::CLS_META_OTHER;
      end
    end else begin
      n_c   = 2'd3;
      inw_c = hit;
      if (hit) begin
        b1 = item.is_prefetch ? mtc_pkg::CNT_IN_PF : mtc_pkg::CNT_IN_DEMAND;
      end else begin
        b1 = item.is_prefetch ? mtc_pkg::CNT_OUT_PF : mtc_pkg::CNT_OUT_DEMAND;
      end
      if (item.command_kind == mtc_pkg::KIND_CLEAN_EVICT) begin
        b2    = hit ? mtc_pkg::CNT_IN_CE : mtc_pkg::CNT_OUT_CE;
        cls_c = mtc_pkg::CLS_CLEAN_EVICT;
      end else if (item.is_read && !item.is_write) begin
        b2    = hit ? mtc_pkg::CNT_IN_RD : mtc_pkg::CNT_OUT_RD;
        cls_c = mtc_pkg::CLS_READ;
      end else if (item.is_write) begin
        if (!hit) begin
          b2    = mtc_pkg::CNT_OUT_WR;
          cls_c = mtc_pkg::CLS_OTHER_WRITE;
        end else begin
          mark_c = item.has_data;
          unique case (item.command_kind)
            mtc_pkg::KIND_WB_DIRTY: begin
              b2 = mtc_pkg::CNT_IN_WBD; cls_c = mtc_pkg::CLS_WB_DIRTY;
            end
            mtc_pkg::KIND_WB_CLEAN: begin
              b2 = mtc_pkg::CNT_IN_WBC; cls_c = mtc_pkg::CLS_WB_CLEAN;
            end
            mtc_pkg::KIND_WRITE_CLEAN: begin
              b2 = mtc_pkg::CNT_IN_WRC; cls_c = mtc_pkg::CLS_WRITE_CLEAN;
            end
            default: begin
              b2 = mtc_pkg::CNT_IN_OTHER_WR; cls_c = mtc_pkg::CLS_OTHER_WRITE;
            end
          endcase
        end
      end else begin
        b2    = hit ? mtc_pkg::CNT_IN_OTHER : mtc_pkg::CNT_OUT_OTHER;
        cls_c = mtc_pkg::CLS_OTHER;
      end
    end
  end

  // stage 3: first line-aligned address at or above the base
  logic [mtc_pkg::STEP_W-1:0] step_c;
  logic [EW-1:0]              a0;

  always_comb begin
    step_c = mtc_pkg::STEP_W'(1) << s1_sh;
    a0     = {1'b0, s2_lo} & ~EW'(step_c - mtc_pkg::STEP_W'(1));
  end

  // stage 4: line index of the first address
  logic [EW-1:0] li_full;

  always_comb begin
    li_full = (dec.a_start - {1'b0, window_base}) >> s1_sh;
  end

  always_ff @(posedge clk) begin
    if (v1) begin
      s2_lo         <= lo_c;
      dec.cls       <= cls_c;
      dec.in_window <= inw_c;
      dec.mark      <= mark_c;
      dec.n_bump    <= n_c;
      dec.bump      <= {b2, b1, mtc_pkg::CNT_PACKETS};
      dec.hi        <= (s1_rend < s1_wend) ? s1_rend : s1_wend;
    end
    if (v2) begin
      dec.step    <= step_c;
      dec.a_start <= (a0 < {1'b0, window_base}) ? a0 + EW'(step_c) : a0;
    end
    if (v3) begin
      li_start <= li_full[AW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      v1 <= start;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  assign done = v4;

endmodule

FILE: src/mtc_cnt_mem.sv
`timescale 1ns / 1ps

module mtc_cnt_mem #(
  parameter int COUNTER_BITS = mtc_pkg::DEF_COUNTER_BITS
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    rd_en,
  input  mtc_pkg::cnt_idx_t       rd_addr,
  output logic [COUNTER_BITS-1:0] rd_data,
  input  logic                    wr_en,
  input  mtc_pkg::cnt_idx_t       wr_addr,
  input  logic [COUNTER_BITS-1:0] wr_data
);

  logic [COUNTER_BITS-1:0]         mem [mtc_pkg::NUM_COUNTERS];
  logic [mtc_pkg::NUM_COUNTERS-1:0] vld;

  // entries never written since reset read as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (wr_en) begin
      vld[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= vld[rd_addr] ? mem[rd_addr] : '0;
    end
  end

endmodule

FILE: src/mtc_line_map.sv
`timescale 1ns / 1ps

module mtc_line_map #(
  parameter int MAX_LINES = mtc_pkg::DEF_MAX_LINES,
  parameter int AW        = $clog2(MAX_LINES)
) (
  input  logic          clk,
  input  logic          rst,
  output logic          busy,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic          rd_data,
  input  logic          wr_en,      // sets the addressed line
  input  logic [AW-1:0] wr_addr
);

  logic          mem [MAX_LINES];
  logic [AW-1:0] clr_idx;

  // clearing pass after reset, one line per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy    <= 1'b1;
      clr_idx <= '0;
    end else if (busy) begin
      clr_idx <= clr_idx + AW'(1);
      if (clr_idx == AW'(MAX_LINES - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (busy) begin
      mem[clr_idx] <= 1'b0;
    end else if (wr_en) begin
      mem[wr_addr] <= 1'b1;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: src/memory_traffic_classifier_coverage.sv
`timescale 1ns / 1ps

// Channel   Dir  Width  Contents
// cfg       in   2+48   cfg_write, cfg_index, cfg_data (plain register writes)
// s_*       in   72+1   one request: observe a memory request or read a counter
// m_*       out  72+4   one result request for every input request
//
// Steps: a request is accepted, decoded, taken through a counter pass and finished.
// The counter pass reads each counter to bump and writes it back incremented (three
// for a plain request, two for metadata; a counter read only reads), using the
// separate read and write ports of the counter memory. A data write in the window
// then walks its lines, the bitmap read-modify-write handling one line a cycle.
// Reset: the coverage bitmap is swept clear, s_tready low.
// Stalls: a finished result waits in the output register; the next request is
// accepted and worked on meanwhile, holding only at its own finish cycle.

module memory_traffic_classifier_coverage #(
  parameter int MAX_LINES    = mtc_pkg::DEF_MAX_LINES,
  parameter int COUNTER_BITS = mtc_pkg::DEF_COUNTER_BITS
) (
  input  logic                              clk,
  input  logic                              rst,
  // configuration writes
  input  logic                              cfg_write,
  input  logic [mtc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [mtc_pkg::CFG_DATA_W-1:0]    cfg_data,
  // input requests
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // req_address[47:0], req_bytes[56:48], is_metadata[57], is_read[58],
  // is_write[59], has_data[60], is_prefetch[61], command_kind[64:62],
  // counter_index[69:65], zero fill [71:70]
  input  logic [mtc_pkg::S_TDATA_W-1:0]     s_tdata,
  // action[0]
  input  logic                              s_tuser,
  // results
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // in_window[0], new_lines[7:1], lines_covered[22:8], counter_value[70:23],
  // zero fill [71]
  output logic [mtc_pkg::M_TDATA_W-1:0]     m_tdata,
  // packet_class[3:0]
  output logic [mtc_pkg::CLS_W-1:0]         m_tuser
);

  localparam int AW = $clog2(MAX_LINES);
  localparam int EW = mtc_pkg::EADDR_W;
  localparam int CW = COUNTER_BITS;

  // configuration registers
  logic [mtc_pkg::ADDR_W-1:0]   window_base;
  logic [mtc_pkg::WLINES_W-1:0] window_lines;
  logic [mtc_pkg::SHIFT_W-1:0]  line_shift;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_base  <= '0;
      window_lines <= mtc_pkg::WINDOW_LINES_RST;
      line_shift   <= mtc_pkg::LINE_SHIFT_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        mtc_pkg::REG_WINDOW_BASE:  window_base  <= cfg_data;
        mtc_pkg::REG_WINDOW_LINES: window_lines <= cfg_data[mtc_pkg::WLINES_W-1:0];
        mtc_pkg::REG_LINE_SHIFT:   line_shift   <= cfg_data[mtc_pkg::SHIFT_W-1:0];
        default: ;
      endcase
    end
  end

  mtc_pkg::state_t state, state_next;
  mtc_pkg::item_t  item;
  mtc_pkg::dec_t   dec;
  logic [AW-1:0]   li_start;
  logic            dec_start, dec_done;
  logic            accept;

  logic [1:0]                   k;          // counter pass step
  logic [EW-1:0]                a;          // line walk address
  logic [AW-1:0]                li, pend_li;
  logic                         pend;       // bitmap read in flight
  logic [mtc_pkg::NEW_W-1:0]    fresh;
  logic [mtc_pkg::COV_W-1:0]    cov;        // distinct-line count
  logic [mtc_pkg::CVAL_W-1:0]   cval;

  // memory control
  logic              cnt_rd_en, cnt_wr_en;
  mtc_pkg::cnt_idx_t cnt_rd_addr, cnt_wr_addr;
  logic [CW-1:0]     cnt_rd_data, cnt_wr_data;
  logic              map_busy, map_rd_en, map_rd_data, map_wr_en;
  logic [AW-1:0]     map_rd_addr, map_wr_addr;
  logic              line_issue;
  logic [CW+mtc_pkg::CVAL_W-1:0] cnt_ext;

  assign accept = s_tvalid && s_tready;

  mtc_decode #(
    .MAX_LINES (MAX_LINES),
    .AW        (AW)
  ) u_decode (
    .clk          (clk),
    .rst          (rst),
    .start        (dec_start),
    .item         (item),
    .window_base  (window_base),
    .window_lines (window_lines),
    .line_shift   (line_shift),
    .done         (dec_done),
    .dec          (dec),
    .li_start     (li_start)
  );

  mtc_cnt_mem #(
    .COUNTER_BITS (COUNTER_BITS)
  ) u_cnt_mem (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (cnt_rd_en),
    .rd_addr (cnt_rd_addr),
    .rd_data (cnt_rd_data),
    .wr_en   (cnt_wr_en),
    .wr_addr (cnt_wr_addr),
    .wr_data (cnt_wr_data)
  );

  mtc_line_map #(
    .MAX_LINES (MAX_LINES),
    .AW        (AW)
  ) u_line_map (
    .clk     (clk),
    .rst     (rst),
    .busy    (map_busy),
    .rd_en   (map_rd_en),
    .rd_addr (map_rd_addr),
    .rd_data (map_rd_data),
    .wr_en   (map_wr_en),
    .wr_addr (map_wr_addr)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      mtc_pkg::ST_IDLE:  if (accept) state_next = mtc_pkg::ST_DEC;
      mtc_pkg::ST_DEC:   if (dec_done) state_next = mtc_pkg::ST_CNT;
      mtc_pkg::ST_CNT: begin
        if (item.action) begin
          if (k == 2'd1) state_next = mtc_pkg::ST_DONE;
        end else if (k == dec.n_bump) begin
          state_next = dec.mark ? mtc_pkg::ST_LINES : mtc_pkg::ST_DONE;
        end
      end
      mtc_pkg::ST_LINES: if (!line_issue && !pend) state_next = mtc_pkg::ST_DONE;
      mtc_pkg::ST_DONE:  if (!m_tvalid || m_tready) state_next = mtc_pkg::ST_IDLE;
      default:           state_next = mtc_pkg::ST_IDLE;
    endcase
  end

  // outputs and memory control
  always_comb begin
    s_tready    = (state == mtc_pkg::ST_IDLE) && !map_busy;
    cnt_rd_en   = 1'b0;
    cnt_wr_en   = 1'b0;
    cnt_rd_addr = item.counter_index;
    cnt_wr_addr = dec.bump[0];
    map_rd_en   = 1'b0;
    map_wr_en   = 1'b0;
    map_rd_addr = li;
    map_wr_addr = pend_li;
    line_issue  = 1'b0;
    // saturating bump of the counter read last cycle
    cnt_wr_data = (cnt_rd_data == '1) ? cnt_rd_data : cnt_rd_data + CW'(1);
    if (state == mtc_pkg::ST_CNT) begin
      if (item.action) begin
        cnt_rd_en = (k == 2'd0) &&
                    (item.counter_index < mtc_pkg::CIDX_W'(mtc_pkg::NUM_COUNTERS));
      end else begin
        cnt_rd_en = (k < dec.n_bump);
        cnt_wr_en = (k != 2'd0);
        case (k)
          2'd0:    cnt_rd_addr = dec.bump[0];
          2'd1:    cnt_rd_addr = dec.bump[1];
          default: cnt_rd_addr = dec.bump[2];
        endcase
        case (k)
          2'd2:    cnt_wr_addr = dec.bump[1];
          2'd3:    cnt_wr_addr = dec.bump[2];
          default: cnt_wr_addr = dec.bump[0];
        endcase
      end
    end
    if (state == mtc_pkg::ST_LINES) begin
      line_issue = (a < dec.hi);
      map_rd_en  = line_issue;
      // a line already covered stays as it is
      map_wr_en  = pend && !map_rd_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= mtc_pkg::ST_IDLE;
      dec_start <= 1'b0;
      m_tvalid  <= 1'b0;
      cov       <= '0;
      k         <= 2'd0;
      pend      <= 1'b0;
    end else begin
      state     <= state_next;
      dec_start <= accept;
      if (map_wr_en && (cov != '1)) begin
        cov <= cov + mtc_pkg::COV_W'(1);
      end
      if (state == mtc_pkg::ST_CNT) begin
        k <= k + 2'd1;
      end else begin
        k <= 2'd0;
      end
      pend <= (state == mtc_pkg::ST_LINES) && line_issue;
      if ((state == mtc_pkg::ST_DONE) && (state_next == mtc_pkg::ST_IDLE)) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  assign cnt_ext = {{mtc_pkg::CVAL_W{1'b0}}, cnt_rd_data};

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      item.action        <= s_tuser;
      item.req_address   <= s_tdata[47:0];
      item.req_bytes     <= s_tdata[56:48];
      item.is_metadata   <= s_tdata[57];
      item.is_read       <= s_tdata[58];
      item.is_write      <= s_tdata[59];
      item.has_data      <= s_tdata[60];
      item.is_prefetch   <= s_tdata[61];
      item.command_kind  <= s_tdata[64:62];
      item.counter_index <= s_tdata[69:65];
      fresh              <= '0;
      cval               <= '0;
    end
    if ((state == mtc_pkg::ST_DEC) && dec_done) begin
      a  <= dec.a_start;
      li <= li_start;
    end
    if ((state == mtc_pkg::ST_CNT) && item.action && (k == 2'd1)) begin
      if (item.counter_index < mtc_pkg::CIDX_W'(mtc_pkg::NUM_COUNTERS)) begin
        cval <= cnt_ext[mtc_pkg::CVAL_W-1:0];
      end else if (item.counter_index == mtc_pkg::CNT_DISTINCT) begin
        cval <= mtc_pkg::CVAL_W'(cov);
      end else begin
        cval <= '0;
      end
    end
    if (line_issue) begin
      a       <= a + EW'(dec.step);
      li      <= li + AW'(1);
      pend_li <= li;
    end
    if (map_wr_en) begin
      fresh <= fresh + mtc_pkg::NEW_W'(1);
    end
    if ((state == mtc_pkg::ST_DONE) && (state_next == mtc_pkg::ST_IDLE)) begin
      m_tdata <= {1'b0, cval, cov, fresh, dec.in_window};
      m_tuser <= dec.cls;
    end
  end

endmodule

FILE: dv/tb_memory_traffic_classifier_coverage.sv
`timescale 1ns / 1ps

// Checks the memory traffic classifier end to end: requests go in on the s_ stream,
// results come back on the m_ stream, and a transaction-level copy of the classifier
// (counters, line bitmap, window registers) predicts every result at accept time.
module tb_memory_traffic_classifier_coverage;
  import mtc_pkg::*;

  // One result, fields in the order they are compared.
  typedef struct packed {
    logic [CLS_W-1:0]  cls;
    logic              in_window;
    logic [NEW_W-1:0]  new_lines;
    logic [COV_W-1:0]  lines_covered;
    logic [CVAL_W-1:0] counter_value;
  } outcome_t;

  // Classifier state plus the queue of results still owed by the block.
  class coverage_predictor;
    logic [ADDR_W-1:0]   window_base;
    logic [WLINES_W-1:0] window_lines;
    logic [SHIFT_W-1:0]  line_shift;
    logic [CVAL_W-1:0]   event_count [NUM_COUNTERS];
    bit                  line_seen [DEF_MAX_LINES];
    logic [COV_W-1:0]    lines_seen;
    outcome_t            awaited [$];
    int                  mismatches;

    function new();
      window_base  = '0;
      window_lines = WINDOW_LINES_RST;
      line_shift   = LINE_SHIFT_RST;
      foreach (event_count[i]) event_count[i] = '0;
      foreach (line_seen[i]) line_seen[i] = 1'b0;
      lines_seen = '0;
      mismatches = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        REG_WINDOW_BASE:  window_base  = val[ADDR_W-1:0];
        REG_WINDOW_LINES: window_lines = val[WLINES_W-1:0];
        REG_LINE_SHIFT:   line_shift   = val[SHIFT_W-1:0];
        default: ;
      endcase
    endfunction

    // out-of-range register values are clamped, not rejected
    function longint unsigned eff_shift();
      if (line_shift < SH_MIN) return SH_MIN;
      if (line_shift > SH_MAX) return SH_MAX;
      return line_shift;
    endfunction

    function longint unsigned eff_lines();
      return (window_lines > DEF_MAX_LINES) ? DEF_MAX_LINES : window_lines;
    endfunction

    function void bump(cnt_idx_t idx);
      if (event_count[idx] != '1) event_count[idx] = event_count[idx] + 1'b1;
    endfunction

    function int pending();
      return awaited.size();
    endfunction

    function void take_request(item_t it);
      outcome_t        o;
      longint unsigned sh, lines, wbase, wend, addr, nbytes, rend, lo, hi, stp, a, li;
      bit              hit;
      int              fresh;
      o     = '0;
      fresh = 0;
      if (it.action) begin
        if (it.counter_index < NUM_COUNTERS) o.counter_value = event_count[it.counter_index];
        else if (it.counter_index == CNT_DISTINCT) o.counter_value = CVAL_W'(lines_seen);
      end else begin
        bump(CNT_PACKETS);
        if (it.is_metadata) begin
          if (it.is_read) begin
            bump(CNT_META_RD);
            o.cls = CLS_META_RD;
          end else if (it.is_write) begin
            bump(CNT_META_WR);
            o.cls = CLS_META_WR;
          end else begin
            bump(CNT_META_OTHER);
            o.cls = CLS_META_OTHER;
          end
        end else begin
          sh     = eff_shift();
          lines  = eff_lines();
          wbase  = 64'(window_base);
          wend   = wbase + (lines << sh);      // exact, may pass 2^48
          addr   = 64'(it.req_address);
          nbytes = (it.req_bytes > MAX_REQ_BYTES) ? MAX_REQ_BYTES : it.req_bytes;
          rend   = addr + nbytes;
          hit    = lines != 0 && nbytes != 0 && addr < wend && wbase < rend;
          o.in_window = hit;
          if (hit) bump(it.is_prefetch ? CNT_IN_PF : CNT_IN_DEMAND);
          else bump(it.is_prefetch ? CNT_OUT_PF : CNT_OUT_DEMAND);

          if (it.command_kind == KIND_CLEAN_EVICT) begin
            bump(hit ? CNT_IN_CE : CNT_OUT_CE);
            o.cls = CLS_CLEAN_EVICT;
          end else if (it.is_read && !it.is_write) begin
            bump(hit ? CNT_IN_RD : CNT_OUT_RD);
            o.cls = CLS_READ;
          end else if (it.is_write) begin
            if (!hit) begin
              bump(CNT_OUT_WR);
              o.cls = CLS_OTHER_WRITE;
            end else begin
              case (it.command_kind)
                KIND_WB_DIRTY: begin
                  bump(CNT_IN_WBD);
                  o.cls = CLS_WB_DIRTY;
                end
                KIND_WB_CLEAN: begin
                  bump(CNT_IN_WBC);
                  o.cls = CLS_WB_CLEAN;
                end
                KIND_WRITE_CLEAN: begin
                  bump(CNT_IN_WRC);
                  o.cls = CLS_WRITE_CLEAN;
                end
                default: begin
                  bump(CNT_IN_OTHER_WR);
                  o.cls = CLS_OTHER_WRITE;
                end
              endcase
              if (it.has_data) begin
                // mark every line of the overlap; lines below an unaligned base don't count
                lo  = (addr > wbase) ? addr : wbase;
                hi  = (rend < wend) ? rend : wend;
                stp = 64'd1 << sh;
                for (a = lo & ~(stp - 1); a < hi; a += stp) begin
                  if (a < wbase) continue;
                  li = (a - wbase) >> sh;
                  if (li < lines && !line_seen[li]) begin
                    line_seen[li] = 1'b1;
                    fresh++;
                    if (lines_seen != '1) lines_seen = lines_seen + 1'b1;
                  end
                end
              end
            end
          end else begin
            bump(hit ? CNT_IN_OTHER : CNT_OUT_OTHER);
            o.cls = CLS_OTHER;
          end
        end
      end
      o.new_lines     = NEW_W'(fresh);
      o.lines_covered = lines_seen;
      awaited.push_back(o);
    endfunction

    function void match_outcome(outcome_t got);
      outcome_t exp;
      bit       bad;
      if (awaited.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: result with nothing outstanding: class %0d value %0h",
                   $realtime, got.cls, got.counter_value);
        return;
      end
      exp = awaited.pop_front();
      bad = (got.cls !== exp.cls) || (got.in_window !== exp.in_window) ||
            (got.new_lines !== exp.new_lines) || (got.lines_covered !== exp.lines_covered) ||
            (got.counter_value !== exp.counter_value);
      if (bad) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"%0t: mismatch (exp/got) class %0d/%0d in_window %0d/%0d ",
                    "new_lines %0d/%0d covered %0d/%0d value %0h/%0h"}, $realtime,
                   exp.cls, got.cls, exp.in_window, got.in_window, exp.new_lines,
                   got.new_lines, exp.lines_covered, got.lines_covered,
                   exp.counter_value, got.counter_value);
      end
    endfunction
  endclass

  logic                  clk;
  logic                  rst;
  logic                  cfg_write;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [S_TDATA_W-1:0]  s_tdata;
  logic                  s_tuser;
  logic                  m_tvalid;
  logic                  m_tready;
  logic [M_TDATA_W-1:0]  m_tdata;
  logic [CLS_W-1:0]      m_tuser;

  coverage_predictor model;

  // idle odds in percent per cycle; hold_request asks the receiver for a long stall
  int send_idle_pct = 30;
  int recv_idle_pct = 50;
  bit hold_request  = 1'b0;

  memory_traffic_classifier_coverage DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Hard stop; a correct run finishes far earlier (bitmap sweep plus ~1350 requests).
  initial begin
    #8_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  // Receiver: random backpressure, or a long counted hold-off when asked for one so
  // the output register fills and the block stops taking requests.
  initial begin : receiver
    int hold_left;
    hold_left = 0;
    m_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Monitor: both handshakes sampled at the edge, before any new drive lands.
  always @(posedge clk) begin : monitor
    item_t    it;
    outcome_t got;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        it.action        = s_tuser;
        it.req_address   = s_tdata[47:0];
        it.req_bytes     = s_tdata[56:48];
        it.is_metadata   = s_tdata[57];
        it.is_read       = s_tdata[58];
        it.is_write      = s_tdata[59];
        it.has_data      = s_tdata[60];
        it.is_prefetch   = s_tdata[61];
        it.command_kind  = s_tdata[64:62];
        it.counter_index = s_tdata[69:65];
        model.take_request(it);
      end
      if (m_tvalid && m_tready) begin
        got.cls           = m_tuser;
        got.in_window     = m_tdata[0];
        got.new_lines     = m_tdata[7:1];
        got.lines_covered = m_tdata[22:8];
        got.counter_value = m_tdata[70:23];
        model.match_outcome(got);
      end
    end
  end

  // One request onto the stream; returns in the step right after the accept edge.
  task automatic send_request(item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= it.action;
    s_tdata  <= {2'b00, it.counter_index, it.command_kind, it.is_prefetch, it.has_data,
                 it.is_write, it.is_read, it.is_metadata, it.req_bytes, it.req_address};
    do @(posedge clk); while (!s_tready);
  endtask

  // Wait out every outstanding result, then the block's worst walk time.
  // One edge first so the last accept has reached the predictor.
  task automatic wait_quiet();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (model.pending() != 0) @(posedge clk);
    repeat (150) @(posedge clk);
  endtask

  // Write all three window registers back to back; the block is idle here.
  task automatic program_window(logic [CFG_DATA_W-1:0] base, logic [CFG_DATA_W-1:0] lines_word,
                                logic [CFG_DATA_W-1:0] shift_word);
    cfg_write <= 1'b1;
    cfg_index <= REG_WINDOW_BASE;
    cfg_data  <= base;
    model.write_reg(REG_WINDOW_BASE, base);
    @(posedge clk);
    cfg_index <= REG_WINDOW_LINES;
    cfg_data  <= lines_word;
    model.write_reg(REG_WINDOW_LINES, lines_word);
    @(posedge clk);
    cfg_index <= REG_LINE_SHIFT;
    cfg_data  <= shift_word;
    model.write_reg(REG_LINE_SHIFT, shift_word);
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  function automatic item_t mk(logic act, logic [ADDR_W-1:0] addr, logic [BYTES_W-1:0] nbytes,
                               logic meta, logic rd, logic wr, logic data, logic pf,
                               logic [KIND_W-1:0] kind, logic [CIDX_W-1:0] cidx);
    item_t it;
    it.action        = act;
    it.req_address   = addr;
    it.req_bytes     = nbytes;
    it.is_metadata   = meta;
    it.is_read       = rd;
    it.is_write      = wr;
    it.has_data      = data;
    it.is_prefetch   = pf;
    it.command_kind  = kind;
    it.counter_index = cidx;
    return it;
  endfunction

  // Mostly requests that land on or near the window, many of them data writes,
  // so the bitmap and in-window counters get real traffic; the rest is noise.
  function automatic item_t rand_request();
    item_t           it;
    int unsigned     roll, span;
    longint unsigned wsize;
    longint          off;
    it.action        = ($urandom_range(99) < 15);
    it.counter_index = $urandom_range(31);
    it.is_metadata   = ($urandom_range(99) < 10);
    it.is_prefetch   = $urandom_range(1);
    wsize = model.eff_lines() << model.eff_shift();
    if ($urandom_range(99) < 80) begin
      // a narrow span near the base revisits lines; the full span spreads out
      span = (wsize > 2048 && $urandom_range(1)) ? 2048 : int'(wsize);
      off  = longint'($urandom_range(span + 1024)) - 512;
      it.req_address = ADDR_W'(64'(model.window_base) + off);
    end else begin
      it.req_address = ADDR_W'({$urandom, $urandom});
    end
    roll = $urandom_range(99);
    if (roll < 70) it.req_bytes = $urandom_range(1, MAX_REQ_BYTES);
    else if (roll < 80) it.req_bytes = '0;
    else if (roll < 90) it.req_bytes = $urandom_range(MAX_REQ_BYTES + 1, 511);
    else it.req_bytes = $urandom_range(511);
    roll = $urandom_range(99);
    if (roll < 45) begin
      it.is_write     = 1'b1;
      it.has_data     = 1'b1;
      it.is_read      = ($urandom_range(3) == 0);
      it.command_kind = $urandom_range(KIND_WRITE_CLEAN);
    end else if (roll < 70) begin
      it.is_write     = 1'b0;
      it.is_read      = 1'b1;
      it.has_data     = $urandom_range(1);
      it.command_kind = $urandom_range(KIND_WRITE_CLEAN);
    end else begin
      it.is_write     = $urandom_range(1);
      it.is_read      = $urandom_range(1);
      it.has_data     = $urandom_range(1);
      it.command_kind = $urandom_range(7);
    end
    return it;
  endfunction

  task automatic run_random(int count);
    repeat (count) send_request(rand_request());
  endtask

  initial begin : stimulus
    logic [CFG_DATA_W-1:0] p_base [1:7];
    logic [CFG_DATA_W-1:0] p_lines [1:7];
    logic [CFG_DATA_W-1:0] p_shift [1:7];
    item_t                 directed [$];

    rst       <= 1'b1;
    cfg_write <= 1'b0;
    cfg_index <= REG_WINDOW_BASE;
    cfg_data  <= '0;
    s_tvalid  <= 1'b0;
    s_tdata   <= '0;
    s_tuser   <= 1'b0;
    model = new();

    // Window settings per phase: small lines, big lines, a window running past the
    // top of the address space, an empty window, clamped values, top-most base,
    // and junk above the register widths.
    p_base[1]  = 48'({$urandom, $urandom}) & ~48'h3;
    p_lines[1] = 48'd64;
    p_shift[1] = 48'd2;
    p_base[2]  = 48'({$urandom, $urandom});
    p_lines[2] = 48'd300;
    p_shift[2] = 48'd12;
    p_base[3]  = 48'hFFFF_FFF8_0000;
    p_lines[3] = 48'd16384;
    p_shift[3] = 48'd6;
    p_base[4]  = 48'({$urandom, $urandom});
    p_lines[4] = 48'd0;
    p_shift[4] = 48'd0;
    p_base[5]  = 48'd0;
    p_lines[5] = 48'd32767;
    p_shift[5] = 48'd15;
    p_base[6]  = 48'hFFFF_FFFF_FFFF;
    p_lines[6] = 48'd5;
    p_shift[6] = 48'd3;
    p_base[7]  = 48'({$urandom, $urandom}) & ~48'hFFFF;
    p_lines[7] = {33'($urandom), 15'd16384};
    p_shift[7] = {44'($urandom), 4'd2};

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Reset window is one 64-byte line at address 0. s_tready stays low through the
    // bitmap sweep; send_request just waits for it.
    directed.push_back(mk(1, 0, 0, 0, 0, 0, 0, 0, KIND_OTHER, CNT_PACKETS));  // all zero
    directed.push_back(mk(0, 48'h10, 4, 1, 1, 0, 0, 0, KIND_OTHER, 0));       // metadata read
    directed.push_back(mk(0, 0, 4, 1, 0, 1, 1, 0, KIND_WB_DIRTY, 0));         // metadata write
    directed.push_back(mk(0, 0, 4, 1, 0, 0, 0, 1, 3'd7, 5'd31));              // metadata other
    directed.push_back(mk(0, 0, 1, 0, 1, 1, 1, 0, KIND_CLEAN_EVICT, 0));      // evict wins
    directed.push_back(mk(0, 48'd63, 1, 0, 1, 0, 0, 1, KIND_OTHER, 0));       // last byte in
    directed.push_back(mk(0, 48'd64, 1, 0, 1, 0, 0, 0, KIND_OTHER, 0));       // first byte out
    directed.push_back(mk(0, 0, 256, 0, 0, 1, 1, 0, KIND_WB_DIRTY, 0));       // marks line 0
    directed.push_back(mk(0, 48'd32, 8, 0, 0, 1, 1, 0, KIND_WB_CLEAN, 0));    // already marked
    directed.push_back(mk(0, 48'd8, 8, 0, 0, 1, 0, 1, KIND_WRITE_CLEAN, 0));  // no payload
    directed.push_back(mk(0, 48'd8, 8, 0, 1, 1, 1, 0, KIND_OTHER, 0));        // other write
    directed.push_back(mk(0, 48'd5, 8, 0, 1, 1, 1, 0, 3'd6, 0));              // unknown kind
    directed.push_back(mk(0, 48'd64, 256, 0, 0, 1, 1, 0, KIND_WB_DIRTY, 0));  // write outside
    directed.push_back(mk(0, 0, 8, 0, 0, 0, 1, 0, KIND_WB_DIRTY, 0));         // kind w/o write
    directed.push_back(mk(0, 48'hFFFF_FFFF_FFFF, 256, 0, 0, 0, 0, 1, 3'd5, 0));
    directed.push_back(mk(0, 0, 0, 0, 0, 1, 1, 0, KIND_WB_DIRTY, 0));         // zero length
    directed.push_back(mk(0, 0, 9'h1FF, 0, 1, 0, 0, 1, KIND_OTHER, 0));       // length clamp
    directed.push_back(mk(1, 48'hFFFF_FFFF_FFFF, 9'h1FF, 1, 1, 1, 1, 1, 3'd7, CNT_DISTINCT));
    directed.push_back(mk(1, 0, 0, 0, 0, 0, 0, 0, KIND_OTHER, CNT_OUT_WR));
    directed.push_back(mk(1, 0, 0, 0, 0, 0, 0, 0, KIND_OTHER, 5'd20));        // unused index
    directed.push_back(mk(1, 0, 0, 0, 0, 0, 0, 0, KIND_OTHER, 5'd31));
    foreach (directed[i]) send_request(directed[i]);
    run_random(160);

    for (int p = 1; p <= 7; p++) begin
      wait_quiet();
      program_window(p_base[p], p_lines[p], p_shift[p]);
      // idle pattern: sender-light first, then receiver-light, then none at all
      if (p >= 6) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end else if (p >= 3) begin
        send_idle_pct = 50;
        recv_idle_pct = 30;
      end
      if (p == 1 || p == 5) hold_request = 1'b1;   // long output stall while we keep sending
      if (p == 2) begin
        run_random(83);
        // sender stops until every result is back, then resumes
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (model.pending() != 0) @(posedge clk);
        run_random(83);
      end else begin
        run_random(166);
      end
    end

    wait_quiet();
    if (model.mismatches == 0 && model.pending() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

FILE: memory_traffic_classifier_coverage.f
src/mtc_pkg.sv
src/mtc_decode.sv
src/mtc_cnt_mem.sv
src/mtc_line_map.sv
src/memory_traffic_classifier_coverage.sv
dv/tb_memory_traffic_classifier_coverage.sv
